// File: sv/bl3_pkg.sv
// bl3_pkg: shared constants, types and helper functions of the 3x3 blur filter
// used by bl3_window, bl3_kernel and normalized_3x3_blur_filter
// no dependencies
`default_nettype none

package bl3_pkg;

    // frame geometry
    localparam int MAX_LINE_PIXELS = 1024;
    localparam int KERNEL_SPAN     = 3;
    localparam int COL_W           = $clog2(MAX_LINE_PIXELS);

    // pixel and arithmetic widths
    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;
    localparam int SUM_W = 12;
    localparam int LINE_W = 2 * PIX_W;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0]     FRAME_WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0]     FRAME_HEIGHT_RESET = CFG_W'(480);

    // result queue and credit
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int OCC_W      = $clog2(FIFO_DEPTH + 1);

    // reciprocal constants: x/3 for x < 768 and x/5 for x < 1280
    localparam int RECIP_3       = 683;
    localparam int RECIP_3_SHIFT = 11;
    localparam int RECIP_5       = 3277;
    localparam int RECIP_5_SHIFT = 14;

    // stream payload widths
    localparam int IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;
    localparam int OUT_BITS    = PIX_W + 2 * COL_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // window row 0 is the oldest line, column 2 the newest pixel
    typedef rgb_t [KERNEL_SPAN-1:0][KERNEL_SPAN-1:0] window_t;
    typedef rgb_t [KERNEL_SPAN-1:0] column_t;

    // position of an input pixel handed to the window
    typedef struct packed {
        logic [COL_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last_col;
        logic             last_row;
    } item_t;

    // one output pixel to compute from the current window
    typedef struct packed {
        logic             valid;
        logic             cr2;
        logic             cc2;
        logic             top;
        logic             left;
        logic [COL_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } issue_t;

    typedef enum logic [1:0] {
        DIV_12,
        DIV_8,
        DIV_5
    } div_kind_t;

    typedef struct packed {
        rgb_t             pix;
        logic [COL_W-1:0] col;
        logic [COL_W-1:0] row;
        logic             last;
    } result_t;

    // clamp a size register to 2..MAX_LINE_PIXELS and return size - 1
    function automatic logic [COL_W-1:0] size_last(input logic [CFG_W-1:0] v);
        int s;
        s = int'(v);
        if (s < 2) begin
            s = 2;
        end else if (s > MAX_LINE_PIXELS) begin
            s = MAX_LINE_PIXELS;
        end
        return COL_W'(s - 1);
    endfunction

    // kernel weights 1,2,1 / 2,0,2 / 1,2,1
    function automatic logic [1:0] kernel_weight(input int i, input int j);
        if (i == 1 && j == 1) begin
            return 2'd0;
        end else if (i == 1 || j == 1) begin
            return 2'd2;
        end
        return 2'd1;
    endfunction

endpackage

`default_nettype wire

// File: sv/normalized_3x3_blur_filter.sv
// normalized_3x3_blur_filter: streaming 3x3 blur with border renormalisation
// results pass the read stage, window, kernel sum stage and result queue in order
// throughput: 1 pixel per cycle while the queue has credit; a pixel releasing n results
// holds the input until its last issues, results leaving the issue sequencer one per
// cycle (n is 2 in the last column or row, 4 at the last pixel of a frame)
// reset: counters, window and queue cleared, size 640x480; line ram not cleared
`default_nettype none

module normalized_3x3_blur_filter
    import bl3_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // red, green, blue
    // output stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_TDATA_W-1:0] m_tdata,   // out_red, out_green, out_blue,
                                                   // out_column, out_row, zero pad
    output logic                        m_tlast,   // last_of_run
    // configuration
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    logic [COL_W-1:0]   width_last_reg;
    logic [COL_W-1:0]   height_last_reg;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   row_reg;
    logic               in_last_col;
    logic               in_last_row;

    logic               s1_valid_reg;
    rgb_t               s1_pix_reg;
    item_t              s1_item_reg;

    logic               s_accept;
    logic               s1_adv;
    logic               m_accept;
    rgb_t               in_pix;

    logic [LINE_W-1:0]  ram_rdata;
    logic [LINE_W-1:0]  ram_wdata;
    column_t            new_col;

    window_t            win;
    issue_t             issue;
    logic               em_free;
    logic               issue_ok;

    logic               res_valid;
    result_t            res;

    result_t            fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [OCC_W-1:0]   cnt_reg;
    logic [OCC_W-1:0]   cnt_next;
    logic [OCC_W-1:0]   occ_reg;
    logic [OCC_W-1:0]   occ_next;
    result_t            head;

    // handshakes
    assign in_pix.red   = s_tdata[0 +: CH_W];
    assign in_pix.green = s_tdata[CH_W +: CH_W];
    assign in_pix.blue  = s_tdata[2*CH_W +: CH_W];
    assign s1_adv       = s1_valid_reg && em_free;
    assign s_tready     = !s1_valid_reg || em_free;
    assign s_accept     = s_tvalid && s_tready;
    assign m_accept     = m_tvalid && m_tready;
    assign in_last_col  = (col_reg == width_last_reg);
    assign in_last_row  = (row_reg == height_last_reg);

    // size registers and raster counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_last_reg  <= size_last(FRAME_WIDTH_RESET);
            height_last_reg <= size_last(FRAME_HEIGHT_RESET);
            col_reg         <= '0;
            row_reg         <= '0;
        end
        else
        begin
            priority if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_last_reg  <= size_last(cfg_data);
                    REG_FRAME_HEIGHT: height_last_reg <= size_last(cfg_data);
                    default:          width_last_reg  <= width_last_reg;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (s_accept)
            begin
                if (in_last_col)
                begin
                    col_reg <= '0;
                    row_reg <= in_last_row ? '0 : row_reg + COL_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
            else
            begin
                col_reg <= col_reg;
                row_reg <= row_reg;
            end
        end
    end

    // read stage: line ram data arrives with the pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_pix_reg           <= in_pix;
            s1_item_reg.row      <= row_reg;
            s1_item_reg.col      <= col_reg;
            s1_item_reg.last_col <= in_last_col;
            s1_item_reg.last_row <= in_last_row;
        end
    end

    // line ram: older line in the upper half, newer line in the lower half
    assign ram_wdata  = {ram_rdata[0 +: PIX_W], s1_pix_reg};
    assign new_col[0] = ram_rdata[PIX_W +: PIX_W];
    assign new_col[1] = ram_rdata[0 +: PIX_W];
    assign new_col[2] = s1_pix_reg;

    bl3_ram #(
        .DEPTH (MAX_LINE_PIXELS),
        .WIDTH (LINE_W)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_item_reg.col),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // window and issue sequencer
    assign issue_ok = (occ_reg < OCC_W'(FIFO_DEPTH));

    bl3_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s1_adv),
        .load_item (s1_item_reg),
        .load_col  (new_col),
        .issue_ok  (issue_ok),
        .win       (win),
        .issue     (issue),
        .free      (em_free)
    );

    // sum and divide
    bl3_kernel u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .win       (win),
        .issue     (issue),
        .res_valid (res_valid),
        .res       (res)
    );

    // result queue, credit covers everything issued and not yet taken
    always_comb
    begin
        cnt_next = cnt_reg + OCC_W'(res_valid) - OCC_W'(m_accept);
        occ_next = occ_reg + OCC_W'(issue.valid) - OCC_W'(m_accept);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            if (res_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (m_accept)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            cnt_reg <= cnt_next;
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            fifo_reg[wr_ptr_reg] <= res;
        end
    end

    // output beat
    assign head     = fifo_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tlast  = head.last;
    assign m_tdata  = {OUT_PAD_W'(0), head.row, head.col,
                       head.pix.blue, head.pix.green, head.pix.red};

    // checks
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(FIFO_DEPTH))
        else $error("result credit above queue depth");

    a_queue_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= occ_reg)
        else $error("queued results not covered by credit");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (cnt_reg < OCC_W'(FIFO_DEPTH)))
        else $error("result written into full queue");

endmodule

`default_nettype wire

// File: sv/bl3_ram.sv
// bl3_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bl3_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/bl3_window.sv
// bl3_window: 3x3 pixel window and the sequencer that issues up to four outputs
// per input pixel; depends on bl3_pkg
`default_nettype none

module bl3_window
    import bl3_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire item_t   load_item,
    input  wire column_t load_col,
    input  wire logic    issue_ok,
    output window_t      win,
    output issue_t       issue,
    output logic         free
);

    window_t          win_reg;
    logic [3:0]       mask_reg;
    logic [3:0]       mask_next;
    logic [COL_W-1:0] em_row_reg;
    logic [COL_W-1:0] em_col_reg;

    logic [1:0]       pick;
    logic [3:0]       remaining;
    logic             fire;

    // results released by the loaded pixel, in output order
    always_comb
    begin
        mask_next[0] = (load_item.row != '0) && (load_item.col != '0);
        mask_next[1] = (load_item.row != '0) && load_item.last_col;
        mask_next[2] = load_item.last_row && (load_item.col != '0);
        mask_next[3] = load_item.last_row && load_item.last_col;
    end

    // lowest pending result goes first
    always_comb
    begin
        priority if (mask_reg[0])
        begin
            pick = 2'd0;
        end
        else if (mask_reg[1])
        begin
            pick = 2'd1;
        end
        else if (mask_reg[2])
        begin
            pick = 2'd2;
        end
        else
        begin
            pick = 2'd3;
        end
    end

    // issue descriptor for the picked result
    always_comb
    begin
        fire            = (mask_reg != '0) && issue_ok;
        remaining       = mask_reg & ~(4'b0001 << pick);
        issue.valid     = fire;
        issue.cr2       = pick[1];
        issue.cc2       = pick[0];
        issue.row       = em_row_reg - COL_W'(!pick[1]);
        issue.col       = em_col_reg - COL_W'(!pick[0]);
        issue.top       = (issue.row == '0);
        issue.left      = (issue.col == '0);
        issue.last      = (remaining == '0);
        free            = ((fire ? remaining : mask_reg) == '0);
    end

    // window shift and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            mask_reg   <= '0;
            em_row_reg <= '0;
            em_col_reg <= '0;
        end
        else
        begin
            if (load)
            begin
                for (int i = 0; i < KERNEL_SPAN; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                    win_reg[i][2] <= load_col[i];
                end
                mask_reg   <= mask_next;
                em_row_reg <= load_item.row;
                em_col_reg <= load_item.col;
            end
            else if (fire)
            begin
                mask_reg <= remaining;
            end
        end
    end

    assign win = win_reg;

endmodule

`default_nettype wire

// File: sv/bl3_kernel.sv
// bl3_kernel: masked 3x3 weighted sum, registered, then combinational reciprocal division
// depends on bl3_pkg
`default_nettype none

module bl3_kernel
    import bl3_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire window_t win,
    input  wire issue_t  issue,
    output logic         res_valid,
    output result_t      res
);

    logic [SUM_W-1:0] sum_next [3];
    div_kind_t        kind_next;

    logic             k1_valid_reg;
    logic [SUM_W-1:0] k1_sum_reg [3];
    div_kind_t        k1_kind_reg;
    logic [COL_W-1:0] k1_row_reg;
    logic [COL_W-1:0] k1_col_reg;
    logic             k1_last_reg;

    logic [CH_W-1:0]  quot [3];

    // weighted sum of the in-frame neighbours
    always_comb
    begin
        logic [1:0]       ri;
        logic [1:0]       cj;
        logic             use_n;
        logic [1:0]       wt;
        rgb_t             nb;
        logic [SUM_W-1:0] term [3];
        for (int c = 0; c < 3; c++)
        begin
            sum_next[c] = '0;
        end
        for (int i = 0; i < KERNEL_SPAN; i++)
        begin
            for (int j = 0; j < KERNEL_SPAN; j++)
            begin
                ri    = (issue.cr2 && i < 2) ? 2'(i + 1) : 2'(i);
                cj    = (issue.cc2 && j < 2) ? 2'(j + 1) : 2'(j);
                use_n = !(i == 0 && issue.top) && !(i == 2 && issue.cr2) &&
                        !(j == 0 && issue.left) && !(j == 2 && issue.cc2);
                wt    = kernel_weight(i, j);
                nb    = win[ri][cj];
                term[0] = SUM_W'(nb.red);
                term[1] = SUM_W'(nb.green);
                term[2] = SUM_W'(nb.blue);
                for (int c = 0; c < 3; c++)
                begin
                    if (!use_n || wt == 2'd0)
                    begin
                        term[c] = '0;
                    end
                    else if (wt == 2'd2)
                    begin
                        term[c] = term[c] << 1;
                    end
                    sum_next[c] = sum_next[c] + term[c];
                end
            end
        end
    end

    // divisor from the clipped sides: 12 inside, 8 on an edge, 5 in a corner
    always_comb
    begin
        logic ex_r;
        logic ex_c;
        ex_r = issue.top || issue.cr2;
        ex_c = issue.left || issue.cc2;
        if (ex_r && ex_c)
        begin
            kind_next = DIV_5;
        end
        else if (ex_r || ex_c)
        begin
            kind_next = DIV_8;
        end
        else
        begin
            kind_next = DIV_12;
        end
    end

    // sum stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_valid_reg <= 1'b0;
        end
        else
        begin
            k1_valid_reg <= issue.valid;
        end
    end

    // sum stage payload
    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            for (int c = 0; c < 3; c++)
            begin
                k1_sum_reg[c] <= sum_next[c];
            end
            k1_kind_reg <= kind_next;
            k1_row_reg  <= issue.row;
            k1_col_reg  <= issue.col;
            k1_last_reg <= issue.last;
        end
    end

    // truncating division, by reciprocal multiplication for 12 and 5 and by a shift for 8
    always_comb
    begin
        logic [2*SUM_W-1:0] prod;
        for (int c = 0; c < 3; c++)
        begin
            unique case (k1_kind_reg)
                DIV_12:
                begin
                    prod    = (2*SUM_W)'(k1_sum_reg[c] >> 2) * (2*SUM_W)'(RECIP_3);
                    quot[c] = prod[RECIP_3_SHIFT +: CH_W];
                end
                DIV_8:
                begin
                    prod    = '0;
                    quot[c] = k1_sum_reg[c][3 +: CH_W];
                end
                DIV_5:
                begin
                    prod    = (2*SUM_W)'(k1_sum_reg[c]) * (2*SUM_W)'(RECIP_5);
                    quot[c] = prod[RECIP_5_SHIFT +: CH_W];
                end
                default:
                begin
                    prod    = '0;
                    quot[c] = '0;
                end
            endcase
        end
    end

    assign res_valid     = k1_valid_reg;
    assign res.pix.red   = quot[0];
    assign res.pix.green = quot[1];
    assign res.pix.blue  = quot[2];
    assign res.col       = k1_col_reg;
    assign res.row       = k1_row_reg;
    assign res.last      = k1_last_reg;

endmodule

`default_nettype wire
